>>> hdl/u2a_pkg.sv
package u2a_pkg;

  // Character counter width and the fixed output count width
  localparam int COUNT_BITS   = 16;
  localparam int CHAR_COUNT_W = 16;
  localparam int CP_W         = 21;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [7:0]      REPL_RESET  = 8'h3F;
  localparam logic [CP_W-1:0] ASCII_LIMIT = 21'h00_0080;
  localparam logic [CP_W-1:0] MIN_3BYTE   = 21'h00_0800;
  localparam logic [CP_W-1:0] SURR_LO     = 21'h00_D800;
  localparam logic [CP_W-1:0] SURR_HI     = 21'h00_DFFF;
  localparam logic [CP_W-1:0] MIN_4BYTE   = 21'h01_0000;
  localparam logic [CP_W-1:0] MAX_POINT   = 21'h10_FFFF;

  // Register word index of the replacement byte
  localparam logic REG_REPL = 1'b0;

  // Byte classes decided by the front end
  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,
    CLS_LEAD2 = 3'd1,
    CLS_LEAD3 = 3'd2,
    CLS_LEAD4 = 3'd3,
    CLS_CONT  = 3'd4,
    CLS_BAD   = 3'd5
  } cls_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_ERROR    = 2'd1,
    KIND_DROP_END = 2'd2
  } kind_e;

  // One classified word between front and back
  typedef struct packed {
    cls_e       cls;
    logic [6:0] bits;
    logic       eos;
  } item_t;

endpackage

>>> hdl/u2a_front.sv
module u2a_front (
  input  logic           in_valid_i,
  input  logic [7:0]     data_byte_i,
  input  logic           end_of_string_i,
  input  logic           q_full_i,
  output logic           in_stall_o,
  output logic           push_o,
  output u2a_pkg::item_t item_o
);
  import u2a_pkg::*;

  // Stall only when the queue has no room
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the byte and keep its payload bits
  always_comb begin
    item_o.eos  = end_of_string_i;
    item_o.bits = data_byte_i[6:0];
    unique case (data_byte_i) inside
      [8'h00:8'h7F]: begin
        item_o.cls = CLS_ASCII;
      end
      [8'h80:8'hBF]: begin
        item_o.cls  = CLS_CONT;
        item_o.bits = {1'b0, data_byte_i[5:0]};
      end
      [8'hC2:8'hDF]: begin
        item_o.cls  = CLS_LEAD2;
        item_o.bits = {2'b00, data_byte_i[4:0]};
      end
      [8'hE0:8'hEF]: begin
        item_o.cls  = CLS_LEAD3;
        item_o.bits = {3'b000, data_byte_i[3:0]};
      end
      [8'hF0:8'hF4]: begin
        item_o.cls  = CLS_LEAD4;
        item_o.bits = {4'b0000, data_byte_i[2:0]};
      end
      default: begin
        item_o.cls = CLS_BAD;
      end
    endcase
  end

endmodule

>>> hdl/u2a_queue.sv
module u2a_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  u2a_pkg::item_t push_item_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output u2a_pkg::item_t head_o
);
  import u2a_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

>>> hdl/u2a_back.sv
module u2a_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  u2a_pkg::item_t item_i,
  output logic           pop_o,
  input  logic [7:0]     repl_byte_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [1:0]     result_kind_o,
  output logic [7:0]     ascii_byte_o,
  output logic [20:0]    code_point_o,
  output logic [15:0]    char_count_o,
  output logic           last_o
);
  import u2a_pkg::*;

  // Decode state
  logic [CP_W-1:0]       partial_q, partial_d;
  logic [1:0]            pend_q, pend_d;
  logic [1:0]            seqlen_q, seqlen_d;
  logic                  drop_q, drop_d;
  logic [COUNT_BITS-1:0] chars_q, chars_d;

  // Output register
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              kind_q, kind_d;
  logic [7:0]              ascii_q, ascii_d;
  logic [CP_W-1:0]         cp_q, cp_d;
  logic [CHAR_COUNT_W-1:0] count_q, count_d;
  logic                    last_q, last_d;

  logic            emit;
  logic            done;
  logic            bad;
  logic [CP_W-1:0] new_point;
  logic [1:0]      pend_dec;
  logic [COUNT_BITS-1:0] chars_inc;

  // Take a word whenever the output slot is free or being drained
  assign pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);

  assign new_point = {partial_q[CP_W-7:0], item_i.bits[5:0]};
  assign pend_dec  = pend_q - 1'b1;
  assign chars_inc = (chars_q == {COUNT_BITS{1'b1}}) ? chars_q : chars_q + 1'b1;

  always_comb begin
    partial_d = partial_q;
    pend_d    = pend_q;
    seqlen_d  = seqlen_q;
    drop_d    = drop_q;
    chars_d   = chars_q;
    emit      = 1'b0;
    done      = 1'b0;
    bad       = 1'b0;
    kind_d    = KIND_CHAR;
    ascii_d   = '0;
    cp_d      = '0;
    count_d   = CHAR_COUNT_W'(chars_q);
    last_d    = item_i.eos;

    if (drop_q) begin
      // Drop bytes until the string ends
      if (item_i.eos) begin
        emit      = 1'b1;
        kind_d    = KIND_DROP_END;
        partial_d = '0;
        pend_d    = '0;
        seqlen_d  = '0;
        drop_d    = 1'b0;
        chars_d   = '0;
      end
    end else begin
      if (pend_q == 2'd0) begin
        unique case (item_i.cls)
          CLS_ASCII: begin
            done = 1'b1;
            cp_d = CP_W'(item_i.bits);
          end
          CLS_LEAD2: begin
            partial_d = CP_W'(item_i.bits);
            pend_d    = 2'd1;
            seqlen_d  = 2'd1;
          end
          CLS_LEAD3: begin
            partial_d = CP_W'(item_i.bits);
            pend_d    = 2'd2;
            seqlen_d  = 2'd2;
          end
          CLS_LEAD4: begin
            partial_d = CP_W'(item_i.bits);
            pend_d    = 2'd3;
            seqlen_d  = 2'd3;
          end
          default: bad = 1'b1;
        endcase
      end else if (item_i.cls != CLS_CONT) begin
        bad = 1'b1;
      end else begin
        partial_d = new_point;
        pend_d    = pend_dec;
        if (pend_dec == 2'd0) begin
          cp_d = new_point;
          // Reject overlong forms, surrogates and out-of-range values
          if (seqlen_q == 2'd2 && (new_point < MIN_3BYTE ||
              (new_point >= SURR_LO && new_point <= SURR_HI))) begin
            bad = 1'b1;
          end else if (seqlen_q == 2'd3 &&
                       (new_point < MIN_4BYTE || new_point > MAX_POINT)) begin
            bad = 1'b1;
          end else begin
            done = 1'b1;
          end
        end
      end

      // Flag a sequence cut short by the end of the string
      if (!bad && !done && item_i.eos) begin
        bad = 1'b1;
      end

      if (bad) begin
        emit      = 1'b1;
        kind_d    = KIND_ERROR;
        cp_d      = '0;
        partial_d = '0;
        pend_d    = '0;
        seqlen_d  = '0;
        if (item_i.eos) begin
          chars_d = '0;
        end else begin
          drop_d = 1'b1;
        end
      end else if (done) begin
        emit      = 1'b1;
        kind_d    = KIND_CHAR;
        ascii_d   = (cp_d < ASCII_LIMIT) ? cp_d[7:0] : repl_byte_i;
        count_d   = CHAR_COUNT_W'(chars_inc);
        chars_d   = chars_inc;
        partial_d = '0;
        seqlen_d  = '0;
        if (item_i.eos) begin
          pend_d  = '0;
          chars_d = '0;
        end
      end
    end
  end

  // Hold a result until it is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      pend_q      <= '0;
      seqlen_q    <= '0;
      drop_q      <= 1'b0;
      chars_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        partial_q <= partial_d;
        pend_q    <= pend_d;
        seqlen_q  <= seqlen_d;
        drop_q    <= drop_d;
        chars_q   <= chars_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      kind_q  <= kind_d;
      ascii_q <= ascii_d;
      cp_q    <= cp_d;
      count_q <= count_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign ascii_byte_o  = ascii_q;
  assign code_point_o  = cp_q;
  assign char_count_o  = count_q;
  assign last_o        = last_q;

endmodule

>>> hdl/utf8_to_ascii_replacer_unit.sv
// UTF-8 to ASCII replacer.
// Input channel: one string byte per word (data_byte_i, end_of_string_i on the
// final byte), accepted when in_valid_i is high and in_stall_o is low.
// Output channel: one word per finished character, per error, and per string
// end after an error; taken when out_valid_o is high and out_stall_i is low.
// Throughput: one byte per cycle while out_stall_i is low; the decoder takes
// one queued byte per cycle and writes any result to the output register.
// A two-word queue sits between the byte classifier and the decoder, and the
// decoder writes into a single output register; when the receiver stalls the
// output register holds, the decoder stops once it holds a result, the queue
// fills, and in_stall_o rises as soon as the queue holds two bytes.
// The replacement byte is written through the APB port at byte address 0
// (reset value 0x3F); write it only while the block is idle.
// Reset clears the queue pointers, the output valid flag and all decode
// state; no clearing pass follows reset.
module utf8_to_ascii_replacer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  ascii_byte_o,
  output logic [20:0] code_point_o,
  output logic [15:0] char_count_o,
  output logic        last_o
);
  import u2a_pkg::*;

  logic [7:0] repl_q;
  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  item_t      push_item;
  item_t      head_item;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= REPL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_REPL) begin
      repl_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_REPL) ? {24'd0, repl_q} : 32'd0;

  u2a_front u_front (
    .in_valid_i      (in_valid_i),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .q_full_i        (q_full),
    .in_stall_o      (in_stall_o),
    .push_o          (push),
    .item_o          (push_item)
  );

  u2a_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head_item)
  );

  u2a_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .item_i        (head_item),
    .pop_o         (pop),
    .repl_byte_i   (repl_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .ascii_byte_o  (ascii_byte_o),
    .code_point_o  (code_point_o),
    .char_count_o  (char_count_o),
    .last_o        (last_o)
  );

endmodule

>>> tb/tb_utf8_to_ascii_replacer_unit.sv
`timescale 1ns / 100ps

module tb_utf8_to_ascii_replacer_unit;
  import u2a_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int HOLD_CYCLES  = 400;

  // One result word as predicted
  typedef struct {
    kind_e       kind;
    logic [7:0]  ascii;
    logic [20:0] point;
    logic [15:0] count;
    logic        last;
  } u2a_word_t;

  // Decode predictor plus the queue of result words still owed by the block
  class utf8_char_checker;
    logic [7:0]            repl;
    logic [20:0]           partial;
    logic [1:0]            pending;
    logic [1:0]            seq_len;
    logic                  dropping;
    logic [COUNT_BITS-1:0] chars;
    u2a_word_t             awaited[$];
    int unsigned           errors;
    int unsigned           live_bytes;

    function new();
      repl = REPL_RESET;
      errors = 0;
      live_bytes = 0;
      clear_string();
    endfunction

    function void clear_string();
      partial  = '0;
      pending  = '0;
      seq_len  = '0;
      dropping = 1'b0;
      chars    = '0;
    endfunction

    function void push_word(kind_e kind, logic [7:0] ascii, logic [20:0] point, logic last);
      u2a_word_t w;
      w.kind  = kind;
      w.ascii = ascii;
      w.point = point;
      w.count = chars[CHAR_COUNT_W-1:0];
      w.last  = last;
      awaited.push_back(w);
    endfunction

    // Predict the result of one accepted byte
    function void note_byte(logic [7:0] b, logic eos);
      logic        done;
      logic        bad;
      logic [20:0] cp;
      done = 1'b0;
      bad  = 1'b0;
      cp   = '0;
      // drop the rest of a broken string, report its end
      if (dropping) begin
        if (eos) begin
          push_word(KIND_DROP_END, 8'h00, '0, 1'b1);
          clear_string();
        end
        return;
      end
      live_bytes++;
      if (pending == 2'd0) begin
        if (b < 8'h80) begin
          cp = {13'd0, b};
          done = 1'b1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          partial = {16'd0, b[4:0]};
          pending = 2'd1;
          seq_len = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          partial = {17'd0, b[3:0]};
          pending = 2'd2;
          seq_len = 2'd2;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          partial = {18'd0, b[2:0]};
          pending = 2'd3;
          seq_len = 2'd3;
        end else begin
          bad = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        bad = 1'b1;
      end else begin
        // gather six more bits, judge the value once complete
        partial = {partial[14:0], b[5:0]};
        pending = pending - 2'd1;
        if (pending == 2'd0) begin
          cp = partial;
          if (seq_len == 2'd2 && (cp < MIN_3BYTE || (cp >= SURR_LO && cp <= SURR_HI)))
            bad = 1'b1;
          else if (seq_len == 2'd3 && (cp < MIN_4BYTE || cp > MAX_POINT))
            bad = 1'b1;
          else
            done = 1'b1;
        end
      end
      // unfinished sequence at the end of the string
      if (!bad && !done && eos)
        bad = 1'b1;
      if (bad) begin
        push_word(KIND_ERROR, 8'h00, '0, eos);
        if (eos) begin
          clear_string();
        end else begin
          partial  = '0;
          pending  = '0;
          seq_len  = '0;
          dropping = 1'b1;
        end
        return;
      end
      if (!done)
        return;
      if (chars != '1)
        chars++;
      partial = '0;
      seq_len = '0;
      push_word(KIND_CHAR, (cp < ASCII_LIMIT) ? cp[7:0] : repl, cp, eos);
      if (eos)
        clear_string();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    // Check one taken result word against the oldest prediction
    function void check_word(logic [1:0] kind, logic [7:0] ascii, logic [20:0] point,
                             logic [15:0] count, logic last);
      u2a_word_t w;
      if (awaited.size() == 0) begin
        $error("result word with none awaited: kind %0d point 0x%0h", kind, point);
        errors++;
        return;
      end
      w = awaited.pop_front();
      compare_field("result_kind", 32'(w.kind), 32'(kind));
      compare_field("ascii_byte", 32'(w.ascii), 32'(ascii));
      compare_field("code_point", 32'(w.point), 32'(point));
      compare_field("char_count", 32'(w.count), 32'(count));
      compare_field("last", 32'(w.last), 32'(last));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        end_of_string_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  result_kind_o;
  logic [7:0]  ascii_byte_o;
  logic [20:0] code_point_o;
  logic [15:0] char_count_o;
  logic        last_o;

  utf8_char_checker sb = new();
  logic [7:0]       string_bytes[$];
  bit               quiet;
  int               hold_left;
  int               cycle_count;

  utf8_to_ascii_replacer_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_string_i (end_of_string_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_kind_o   (result_kind_o),
    .ascii_byte_o    (ascii_byte_o),
    .code_point_o    (code_point_o),
    .char_count_o    (char_count_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watch both handshakes; predict first, then check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_byte(data_byte_i, end_of_string_i);
      if (out_valid_o && !out_stall_i)
        sb.check_word(result_kind_o, ascii_byte_o, code_point_o, char_count_o, last_o);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_utf8_to_ascii_replacer_unit: errors");
      $finish;
    end
  end

  // Receiver: random stalls, long hold-offs on request, none while quiet
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= !quiet && ($urandom_range(99) < 8);
      end
    end
  end

  // Offer one word and hold it until taken; idle now and then
  task automatic send_word(input logic [7:0] b, input logic eos);
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    end_of_string_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    if (!quiet && $urandom_range(99) < 3) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_string();
    foreach (string_bytes[i])
      send_word(string_bytes[i], i == string_bytes.size() - 1);
    string_bytes.delete();
  endtask

  // Stop sending until every awaited word has been taken, then let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic check_register(input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_REPL, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.compare_field("replacement_byte", 32'(want), 32'(prdata[7:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_replacement(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_REPL, 2'b00};
    pwdata  <= {24'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.repl = v;
    @(posedge clk_i);
    check_register(v);
  endtask

  // Encode a value in exactly nbytes, overlong forms allowed
  task automatic push_point(input logic [20:0] cp, input int nbytes);
    case (nbytes)
      1: string_bytes.push_back(cp[7:0]);
      2: begin
        string_bytes.push_back({3'b110, cp[10:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        string_bytes.push_back({4'b1110, cp[15:12]});
        string_bytes.push_back({2'b10, cp[11:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        string_bytes.push_back({5'b11110, cp[20:18]});
        string_bytes.push_back({2'b10, cp[17:12]});
        string_bytes.push_back({2'b10, cp[11:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic logic [20:0] pick_point(int nbytes);
    logic [20:0] cp;
    case (nbytes)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        // move surrogates up into valid space
        if (cp >= SURR_LO && cp <= SURR_HI)
          cp = cp ^ 21'h2000;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  task automatic push_valid_char();
    int sel;
    int nbytes;
    sel = $urandom_range(9);
    nbytes = (sel < 4) ? 1 : (sel < 6) ? 2 : (sel < 8) ? 3 : 4;
    push_point(pick_point(nbytes), nbytes);
  endtask

  // Append one malformed sequence; a cut-short one may end the string
  task automatic push_fault(output bit at_end);
    int          sel;
    int          len;
    logic [7:0]  b;
    sel    = $urandom_range(7);
    at_end = 1'b0;
    case (sel)
      0: begin
        // refused lead: C0, C1, F5..FF
        len = $urandom_range(12);
        string_bytes.push_back(8'((len < 2) ? 8'hC0 + len : 8'hF5 + (len - 2)));
      end
      1: string_bytes.push_back(8'($urandom_range('h80, 'hBF)));
      2, 7: begin
        len = $urandom_range(2, 4);
        push_point(pick_point(len), len);
        repeat ($urandom_range(1, len - 1)) void'(string_bytes.pop_back());
        if (sel == 7) begin
          at_end = 1'b1;
        end else begin
          b = 8'($urandom_range(255));
          while (b[7:6] == 2'b10) b = 8'($urandom_range(255));
          string_bytes.push_back(b);
        end
      end
      3: push_point(21'($urandom_range(0, 'h7FF)), 3);
      4: push_point(21'($urandom_range(0, 'hFFFF)), 4);
      5: push_point(21'($urandom_range('hD800, 'hDFFF)), 3);
      default: push_point(21'($urandom_range('h110000, 'h13FFFF)), 4);
    endcase
  endtask

  // Mostly well-formed strings, some broken, a few raw noise
  task automatic build_string();
    int mode;
    bit at_end;
    mode = $urandom_range(99);
    if (mode < 8) begin
      repeat ($urandom_range(1, 8)) string_bytes.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 12)) push_valid_char();
      if (mode >= 78) begin
        push_fault(at_end);
        if (!at_end)
          repeat ($urandom_range(0, 3)) push_valid_char();
      end
    end
  endtask

  task automatic random_phase(input int unsigned target);
    int unsigned start;
    start = sb.live_bytes;
    while (sb.live_bytes - start < target) begin
      build_string();
      send_string();
      if ($urandom_range(99) < 3)
        wait_idle();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    end_of_string_i = 1'b0;
    out_stall_i     = 1'b0;
    quiet           = 1'b0;
    hold_left       = 0;
    cycle_count     = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_register(REPL_RESET);

    // ASCII extremes
    string_bytes = {8'h00, 8'h7F};
    send_string();
    // two-byte extremes, replaced
    string_bytes = {8'hC2, 8'h80, 8'hDF, 8'hBF};
    send_string();
    // three- and four-byte boundaries up to the top scalar value
    string_bytes = {8'hE0, 8'hA0, 8'h80, 8'hF0, 8'h90, 8'h80, 8'h80,
                    8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
    // refused lead, then drop to the end of the string
    string_bytes = {8'hC0, 8'h41, 8'h42};
    send_string();
    // surrogate on the final byte
    string_bytes = {8'hED, 8'hA0, 8'h80};
    send_string();
    // sequence cut short by the end of the string
    string_bytes = {8'hE0, 8'h80};
    send_string();

    wait_idle();
    write_replacement(8'h00);
    random_phase(300);

    // receiver holds off while the sender keeps offering
    wait_idle();
    write_replacement(8'hFF);
    hold_left = HOLD_CYCLES;
    random_phase(300);

    // back-to-back stretch on both sides
    wait_idle();
    write_replacement(8'($urandom_range(1, 254)));
    quiet = 1'b1;
    random_phase(250);
    quiet = 1'b0;
    random_phase(300);

    wait_idle();
    if (sb.errors == 0)
      $display("tb_utf8_to_ascii_replacer_unit: clean");
    else
      $display("tb_utf8_to_ascii_replacer_unit: errors");
    $finish;
  end

endmodule
